[src/eeb_pkg.sv]
// Shared types and constants for the EEPROM byte master.
`default_nettype none

package eeb_pkg;

    // Bits in one bus byte.
    localparam int BYTE_BITS = 8;
    // Device address width and its value after reset.
    localparam int DEV_W = BYTE_BITS - 1;
    localparam logic [DEV_W-1:0] DEV_ADDR_RESET = 7'd80;
    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Symbols in one byte segment (data bits plus the ack clock).
    localparam int SEG_LEN = BYTE_BITS + 1;
    // Last step of a full write or read sequence and the repeated-start step.
    localparam int SEQ_LAST = 3 * SEG_LEN + 1;
    localparam int RD_RESTART = 2 * SEG_LEN + 1;
    localparam int STEP_W = $clog2(SEQ_LAST + 1);
    localparam int POS_W = $clog2(SEG_LEN);
    localparam int BIDX_W = $clog2(BYTE_BITS);
    localparam int RCNT_W = $clog2(BYTE_BITS);

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_BIT   = 2'd2
    } t_kind;

    // Bus symbols on the result channel.
    typedef enum logic [2:0] {
        SYM_START = 3'd0,
        SYM_STOP  = 3'd1,
        SYM_BIT   = 3'd2,
        SYM_ACK   = 3'd3,
        SYM_READ  = 3'd4
    } t_sym;

    // Jobs that the front hands to the back.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLOCK = 2'd2,
        OP_DONE  = 2'd3
    } t_op;

    // One queued job. data holds the write byte or the completed read byte.
    typedef struct packed {
        t_op                  op;
        logic [DEV_W-1:0]     dev;
        logic [BYTE_BITS-1:0] addr;
        logic [BYTE_BITS-1:0] data;
    } t_job;

endpackage

`default_nettype wire

[src/eeb_if.sv]
// Valid/ready channel interfaces for requests and bus symbols.
`default_nettype none

interface eeb_in_if
    import eeb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [BYTE_BITS-1:0] mem_addr;
    logic [BYTE_BITS-1:0] write_data;
    logic                 sda_in;

    modport source (output valid, kind, mem_addr, write_data, sda_in, input ready);
    modport sink (input valid, kind, mem_addr, write_data, sda_in, output ready);
endinterface

interface eeb_out_if
    import eeb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           symbol;
    logic                 sda_level;
    logic [BYTE_BITS-1:0] read_data;
    logic                 read_valid;
    logic                 last;

    modport source (output valid, symbol, sda_level, read_data, read_valid, last,
                    input ready);
    modport sink (input valid, symbol, sda_level, read_data, read_valid, last,
                  output ready);
endinterface

`default_nettype wire

[src/eeb_front.sv]
// Front end: accepts requests, tracks the read phase and queues jobs.
`default_nettype none

module eeb_front
    import eeb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    eeb_in_if.sink                i_in,
    input  wire logic             i_cfg_we,
    input  wire logic [DEV_W-1:0] i_cfg_wdata,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [DEV_W-1:0]     r_dev;
    logic                 r_reading, n_reading;
    logic [RCNT_W-1:0]    r_cnt, n_cnt;
    logic [BYTE_BITS-1:0] r_shift, n_shift;
    logic                 accept;

    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && !i_q_full;

    // Device address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= DEV_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_dev <= i_cfg_wdata;
        end
    end

    // Classify the item and update the receive state.
    always_comb begin
        n_reading = r_reading;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        o_push    = 1'b0;
        o_job     = '{op: OP_WRITE, dev: r_dev, addr: i_in.mem_addr,
                      data: i_in.write_data};
        if (accept) begin
            case (i_in.kind)
                KIND_WRITE, KIND_READ: begin
                    o_push    = 1'b1;
                    o_job.op  = (i_in.kind == KIND_READ) ? OP_READ : OP_WRITE;
                    n_reading = (i_in.kind == KIND_READ);
                    n_cnt     = '0;
                    n_shift   = '0;
                end
                KIND_BIT: begin
                    if (r_reading) begin
                        o_push = 1'b1;
                        if (r_cnt == RCNT_W'(BYTE_BITS - 1)) begin
                            // Eighth bit completes the byte: nack and stop follow.
                            o_job.op   = OP_DONE;
                            o_job.data = {r_shift[BYTE_BITS-2:0], i_in.sda_in};
                            n_reading  = 1'b0;
                            n_cnt      = '0;
                            n_shift    = '0;
                        end else begin
                            o_job.op = OP_CLOCK;
                            n_cnt    = r_cnt + 1'b1;
                            n_shift  = {r_shift[BYTE_BITS-2:0], i_in.sda_in};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_cnt     <= '0;
            r_shift   <= '0;
        end else begin
            r_reading <= n_reading;
            r_cnt     <= n_cnt;
            r_shift   <= n_shift;
        end
    end

endmodule

`default_nettype wire

[src/eeb_queue.sv]
// Small job queue between the front and the back.
`default_nettype none

module eeb_queue
    import eeb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_nonempty,
    output t_job      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[src/eeb_back.sv]
// Back end: steps through the queued job and emits one bus symbol per transfer.
`default_nettype none

module eeb_back
    import eeb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    eeb_out_if.source o_out
);

    logic [STEP_W-1:0]    r_step;
    logic                 r_ov;
    t_sym                 r_sym;
    logic                 r_lvl;
    logic [BYTE_BITS-1:0] r_rd;
    logic                 r_rv;
    logic                 r_last;

    t_sym                 sym;
    logic                 lvl;
    logic [BYTE_BITS-1:0] rd;
    logic                 rv;
    logic                 lst;
    logic [STEP_W-1:0]    t;
    logic [POS_W-1:0]     pos;
    logic [BYTE_BITS-1:0] seg_byte;
    logic [BIDX_W-1:0]    bidx;
    logic                 is_read;
    logic                 out_free;
    logic                 load;

    assign out_free = !r_ov || o_out.ready;
    assign load     = i_head_valid && out_free;
    assign o_pop    = load && lst;
    assign is_read  = (i_head.op == OP_READ);

    // Locate the current step inside the three byte segments.
    always_comb begin
        if (is_read && r_step > STEP_W'(RD_RESTART)) begin
            t = r_step - STEP_W'(2);
        end else begin
            t = r_step - STEP_W'(1);
        end
        if (t < STEP_W'(SEG_LEN)) begin
            pos      = POS_W'(t);
            seg_byte = {i_head.dev, 1'b0};
        end else if (t < STEP_W'(2 * SEG_LEN)) begin
            pos      = POS_W'(t - STEP_W'(SEG_LEN));
            seg_byte = i_head.addr;
        end else begin
            pos      = POS_W'(t - STEP_W'(2 * SEG_LEN));
            seg_byte = is_read ? {i_head.dev, 1'b1} : i_head.data;
        end
        bidx = BIDX_W'(BYTE_BITS - 1) - BIDX_W'(pos);
    end

    // Symbol for the current step of the head job.
    always_comb begin
        sym = SYM_READ;
        lvl = 1'b1;
        rd  = '0;
        rv  = 1'b0;
        lst = 1'b0;
        case (i_head.op)
            OP_WRITE, OP_READ: begin
                lst = (r_step == STEP_W'(SEQ_LAST));
                if (r_step == '0 || (is_read && r_step == STEP_W'(RD_RESTART))) begin
                    sym = SYM_START;
                    lvl = 1'b0;
                end else if (!is_read && lst) begin
                    sym = SYM_STOP;
                    lvl = 1'b0;
                end else if (pos == POS_W'(BYTE_BITS)) begin
                    sym = SYM_ACK;
                    lvl = 1'b1;
                end else begin
                    sym = SYM_BIT;
                    lvl = seg_byte[bidx];
                end
            end
            OP_CLOCK: begin
                lst = 1'b1;
            end
            OP_DONE: begin
                // Read clock, nack, then stop, all carrying the byte.
                lst = (r_step == STEP_W'(2));
                rd  = i_head.data;
                rv  = 1'b1;
                if (lst) begin
                    sym = SYM_STOP;
                    lvl = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Step counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_ov   <= 1'b0;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_step <= lst ? '0 : r_step + 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym  <= sym;
            r_lvl  <= lvl;
            r_rd   <= rd;
            r_rv   <= rv;
            r_last <= lst;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.symbol     = r_sym;
    assign o_out.sda_level  = r_lvl;
    assign o_out.read_data  = r_rd;
    assign o_out.read_valid = r_rv;
    assign o_out.last       = r_last;

endmodule

`default_nettype wire

[src/i2c_eeprom_byte_master.sv]
// Top level of the I2C EEPROM byte master at bus-symbol level.
//
// Usage: requests arrive on i_in (valid/ready). Kind write and kind read each
// produce a 29-symbol bus sequence on o_out; a sampled SDA bit during a read
// produces one read clock, and the eighth bit produces a read clock, a nack
// and a stop carrying the assembled byte. Each transfer on o_out is one
// symbol; last marks the final symbol of an item.
// The job of each request is registered in the job queue, and each of its
// symbols in the output register. Throughput: one symbol per cycle while
// o_out is ready and jobs are queued; a write or read request gives 29
// symbols, a sampled bit 1 or 3. A two-entry job queue lets new requests
// enter while earlier symbols are still going out.
// The user writes the device address through i_cfg_we/i_cfg_wdata only
// while idle; the block does not enforce this. Reset: the device address
// returns to 80, the read phase is cleared and the queue and output register
// are emptied. When o_out stalls, the current symbol holds; requests keep
// entering until the queue fills, then i_in.ready drops.
`default_nettype none

module i2c_eeprom_byte_master
    import eeb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    eeb_in_if.sink                i_in,
    eeb_out_if.source             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [DEV_W-1:0] i_cfg_wdata
);

    logic q_full;
    logic q_nonempty;
    logic push;
    logic pop;
    t_job job_in;
    t_job head;

    eeb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    eeb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job_in),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    eeb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_nonempty),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

[src/eeb_checker.sv]
// Port-level assertions for the EEPROM byte master, bound to the top level.
`default_nettype none

module eeb_checker
    import eeb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [2:0] i_symbol,
    input wire logic       i_sda_level,
    input wire logic       i_read_valid,
    input wire logic       i_last
);

    // A stalled symbol is held until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_symbol) && $stable(i_last))
        else $error("stalled symbol changed");

    // A completed byte only travels with read clocks, nack or stop.
    a_rv_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_read_valid |-> i_symbol == SYM_READ || i_symbol == SYM_STOP)
        else $error("read byte on wrong symbol");

    // Start never ends an item and drives SDA low.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_symbol == SYM_START |-> !i_last && !i_sda_level && !i_read_valid)
        else $error("bad start symbol");

    // Ack clocks release SDA and never carry a read byte.
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_symbol == SYM_ACK |-> i_sda_level && !i_read_valid)
        else $error("bad ack symbol");

endmodule

bind i2c_eeprom_byte_master eeb_checker u_eeb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_symbol     (o_out.symbol),
    .i_sda_level  (o_out.sda_level),
    .i_read_valid (o_out.read_valid),
    .i_last       (o_out.last)
);

`default_nettype wire
